### rtl/core/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// property holds at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`endif

### rtl/core/ss_pkg.sv
// shared types and constants of the substring search block
// no dependencies; imported by the result interface, the cell, the checker and the top level
package ss_pkg;

    localparam int PATTERN_MAX_DEF   = 16;
    localparam int POSITION_BITS_DEF = 16;

    localparam int PAT_BYTES = 16;
    localparam int PAT_IDX_W = 4;
    localparam int CFG_LEN_W = 5;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int OUT_POS_W = 16;

    localparam logic [1:0] REG_FIRST_EIGHT = 2'd0;
    localparam logic [1:0] REG_LAST_EIGHT  = 2'd1;
    localparam logic [1:0] REG_LENGTH      = 2'd2;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

### rtl/core/ss_text_if.sv
// valid/ready channels for text bytes and search results
// depends on ss_pkg for the position width
interface ss_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ss_result_if
    import ss_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [OUT_POS_W-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink (input valid, input found, input match_position, output ready);
endinterface

### rtl/core/substring_search.sv
// substring_search top level: apb registers, cell chain, match control, result register
// depends on ss_pkg, ss_text_if, ss_result_if and ss_cell
//
// Usage: text bytes enter on the text channel, one per transaction, with
// end_of_text on the final byte of a string. The pattern and its length are
// written over the apb port (64-bit registers at byte addresses 0, 8, 16)
// while no string is in flight. Each byte shifts into a chain of window
// cells that all compare against the pattern at once.
// The result channel carries at most one transaction per string: found with
// the start position of the first match, or not found with position 0 on
// the final byte. Bytes after a match produce nothing.
// A result is registered and visible in the cycle after the byte that caused it.
// Throughput: one byte per cycle while the result is not stalled; the cell compare is combinational.
// Reset clears the pattern registers, the window, the byte count and the
// result valid flag. When the receiver stalls, the result holds in the
// output register and the text channel stops until that result is taken;
// with the result taken, input flows without a bubble.
module substring_search
    import ss_pkg::*;
#(
    parameter int PATTERN_MAX   = PATTERN_MAX_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ss_text_if.sink               text,
    ss_result_if.source           result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};

    logic [63:0]          pattern_first_eight_reg, pattern_first_eight_next;
    logic [63:0]          pattern_last_eight_reg, pattern_last_eight_next;
    logic [CFG_LEN_W-1:0] pattern_length_reg, pattern_length_next;

    logic [POSITION_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic                     match_reported_reg, match_reported_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    logic [OUT_POS_W-1:0]     out_pos_reg, out_pos_next;

    logic                     cfg_write;
    logic [1:0]               cfg_index;
    logic                     accept;
    logic [LEN_W-1:0]         len_eff;
    pattern_t                 pattern;
    cell_ctl_t                ctl;
    logic [PATTERN_MAX-1:0]   hits;
    logic [7:0]               cell_data [PATTERN_MAX];
    logic                     enough;
    logic                     hit;
    logic                     emit;
    logic [POSITION_BITS-1:0] start;
    logic [31:0]              start_w;
    logic [OUT_POS_W-1:0]     start_out;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:3];
    assign cfg_write = psel & penable & pwrite & pready;

    always_comb
    begin
        pattern_first_eight_next = pattern_first_eight_reg;
        pattern_last_eight_next  = pattern_last_eight_reg;
        pattern_length_next      = pattern_length_reg;
        prdata                   = '0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FIRST_EIGHT: pattern_first_eight_next = pwdata;
                REG_LAST_EIGHT:  pattern_last_eight_next  = pwdata;
                REG_LENGTH:      pattern_length_next      = pwdata[CFG_LEN_W-1:0];
                default:         ;
            endcase
        end
        unique case (cfg_index)
            REG_FIRST_EIGHT: prdata = pattern_first_eight_reg;
            REG_LAST_EIGHT:  prdata = pattern_last_eight_reg;
            REG_LENGTH:      prdata = APB_DATA_W'(pattern_length_reg);
            default:         prdata = '0;
        endcase
    end

    assign pattern = {pattern_last_eight_reg, pattern_first_eight_reg};
    assign len_eff = (pattern_length_reg > CFG_LEN_W'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_reg);

    // cell chain
    assign text.ready = !out_valid_reg || result.ready;
    assign accept     = text.valid && text.ready;
    assign ctl.shift  = accept;
    assign ctl.clear  = accept && text.end_of_text;

    for (genvar d = 0; d < PATTERN_MAX; d++)
    begin : g_cell
        logic [7:0] shift_in;
        if (d == 0)
        begin : g_head
            assign shift_in = text.text_byte;
        end
        else
        begin : g_body
            assign shift_in = cell_data[d-1];
        end
        ss_cell #(
            .INDEX (d),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .shift_in    (shift_in),
            .pattern     (pattern),
            .pattern_len (len_eff),
            .data_out    (cell_data[d]),
            .hit         (hits[d])
        );
    end

    // match decision
    always_comb
    begin
        enough = ({1'b0, bytes_seen_reg} + (POSITION_BITS+1)'(1)) >=
                 (POSITION_BITS+1)'(len_eff);
        if (len_eff == '0)
            hit = !match_reported_reg && (bytes_seen_reg == '0);
        else
            hit = !match_reported_reg && enough && (&hits);

        if (len_eff == '0)
            start = '0;
        else if (bytes_seen_reg == POS_LIMIT)
            start = POS_LIMIT;
        else
            start = bytes_seen_reg + POSITION_BITS'(1) - POSITION_BITS'(len_eff);

        start_w   = 32'(start);
        start_out = (start_w > 32'h0000_FFFF) ? 16'hFFFF : start_w[OUT_POS_W-1:0];
        emit      = accept && (hit || (!match_reported_reg && text.end_of_text));
    end

    always_comb
    begin
        bytes_seen_next     = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        if (accept)
        begin
            if (text.end_of_text)
            begin
                bytes_seen_next     = '0;
                match_reported_next = 1'b0;
            end
            else
            begin
                if (bytes_seen_reg != POS_LIMIT)
                    bytes_seen_next = bytes_seen_reg + POSITION_BITS'(1);
                if (hit)
                    match_reported_next = 1'b1;
            end
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_pos_next   = out_pos_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_found_next = hit;
            out_pos_next   = hit ? start_out : '0;
        end
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_first_eight_reg <= '0;
            pattern_last_eight_reg  <= '0;
            pattern_length_reg      <= '0;
            bytes_seen_reg          <= '0;
            match_reported_reg      <= 1'b0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            pattern_first_eight_reg <= pattern_first_eight_next;
            pattern_last_eight_reg  <= pattern_last_eight_next;
            pattern_length_reg      <= pattern_length_next;
            bytes_seen_reg          <= bytes_seen_next;
            match_reported_reg      <= match_reported_next;
            out_valid_reg           <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_pos_reg   <= out_pos_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.found          = out_found_reg;
    assign result.match_position = out_pos_reg;

endmodule

### rtl/core/ss_cell.sv
// one window cell: holds a text byte, passes it on, compares with its pattern byte
// depends on ss_pkg
module ss_cell
    import ss_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int LEN_W = 5
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [7:0]       shift_in,
    input  pattern_t         pattern,
    input  logic [LEN_W-1:0] pattern_len,
    output logic [7:0]       data_out,
    output logic             hit
);

    logic [7:0]           data_reg;
    logic [7:0]           data_next;
    logic [CFG_LEN_W-1:0] sel;

    // window cell d faces pattern byte len-1-d
    always_comb
    begin
        sel = CFG_LEN_W'(pattern_len) - CFG_LEN_W'(INDEX + 1);
        if (CFG_LEN_W'(pattern_len) <= CFG_LEN_W'(INDEX))
            hit = 1'b1;
        else
            hit = (shift_in == pattern[sel[PAT_IDX_W-1:0]]);
    end

    always_comb
    begin
        data_next = data_reg;
        if (ctl.clear)
            data_next = 8'd0;
        else if (ctl.shift)
            data_next = shift_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= 8'd0;
        else
            data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

### rtl/core/ss_checker.sv
// port-level checks of substring_search, attached by bind
// depends on ss_pkg and assert_macros.svh
`include "assert_macros.svh"

module ss_checker
    import ss_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 out_found,
    input logic [OUT_POS_W-1:0] out_pos,
    input logic                 pready
);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_pos))
    `ASSERT_SAME(a_miss_pos_zero, clk, rst_n, out_valid && !out_found, out_pos == '0)
    `ASSERT_SAME(a_stall_blocks_in, clk, rst_n, out_valid && !out_ready, !in_ready)
    `ASSERT_ALWAYS(a_pready_high, clk, rst_n, pready)

endmodule

bind substring_search ss_checker u_ss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (text.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_found (result.found),
    .out_pos   (result.match_position),
    .pready    (pready)
);
